@@ sv/csm_pkg.sv @@
// Shared types and constants for the cron schedule matcher.
`default_nettype none
package csm_pkg;
  localparam int FieldCount = 5;

  // Register indexes; field order follows the same numbering
  localparam logic [2:0] RegMinute  = 3'd0;
  localparam logic [2:0] RegHour    = 3'd1;
  localparam logic [2:0] RegDay     = 3'd2;
  localparam logic [2:0] RegMonth   = 3'd3;
  localparam logic [2:0] RegWeekday = 3'd4;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic match;
    logic malformed;
  } out_item_t;

  // Controller-to-datapath commands
  typedef struct packed {
    logic take;      // parse the held character
    logic close;     // close the open field of a finished line, set the verdict
    logic walk_step; // advance walk by one position
    logic finish;    // clear the parse state after the verdict
  } dp_cmd_t;

  // Datapath-to-controller status
  typedef struct packed {
    logic need_walk; // the pending evaluation needs a range walk
    logic walk_done; // walk produced its answer
  } dp_sts_t;

  function automatic logic [5:0] span_lo(input logic [2:0] f);
    return (f == RegMonth) ? 6'd1 : 6'd0;
  endfunction

  function automatic logic [5:0] span_hi(input logic [2:0] f);
    logic [5:0] r;
    unique case (f)
      RegMinute:  r = 6'd59;
      RegHour:    r = 6'd23;
      RegDay:     r = 6'd31;
      RegMonth:   r = 6'd12;
      RegWeekday: r = 6'd6;
      default: r = 6'd0;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

@@ sv/csm_datapath.sv @@
// Parse registers, current-time registers and the range walker.
`default_nettype none
module csm_datapath #(
  parameter int NUMBER_BITS = 8
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic [2:0]          cfg_index,
  input  wire logic [5:0]          cfg_data,
  input  wire logic [7:0]          ch,
  input  wire csm_pkg::dp_cmd_t    cmd,
  output csm_pkg::dp_sts_t         sts,
  output logic                     match,
  output logic                     malformed
);
  import csm_pkg::*;

  localparam int NB = NUMBER_BITS;
  localparam logic [NB-1:0] MaxNum = {NB{1'b1}};

  typedef enum logic [1:0] {PH_PLAIN, PH_DASH, PH_NUM_STEP, PH_RANGE_STEP} phase_t;
  typedef enum logic [1:0] {PS_EMPTY, PS_STAR, PS_DIGITS, PS_CLOSED} pstar_t;

  logic [5:0] now_minute;
  logic [4:0] now_hour, now_day;
  logic [3:0] now_month;
  logic [2:0] now_weekday;

  logic [2:0]    field_index;
  logic          line_ok, field_hit, error_seen, in_field;
  logic [NB-1:0] number_accum, range_start, range_end;
  phase_t        item_phase;
  pstar_t        part_star;

  // walker
  logic [NB-1:0] w_end, w_step, w_pos, w_cnt;
  logic          pend_field_end;   // evaluation came from a field end
  logic          pend_last;        // set the verdict when the walk ends

  logic [5:0] cur;
  always_comb begin
    unique case (field_index)
      RegMinute:  cur = now_minute;
      RegHour:    cur = {1'b0, now_hour};
      RegDay:     cur = {1'b0, now_day};
      RegMonth:   cur = {2'b0, now_month};
      RegWeekday: cur = {3'b0, now_weekday};
      default: cur = 6'd0;
    endcase
  end

  wire [NB-1:0] lo = NB'(span_lo(field_index));
  wire [NB-1:0] hi = NB'(span_hi(field_index));

  // A line close acts as a final space
  wire       step_in = cmd.take || cmd.close;
  wire       last_e  = cmd.close;
  wire [7:0] ch_e    = cmd.close ? 8'h20 : ch;

  // Decode the held character
  wire is_space = ch_e == 8'h20;
  wire is_comma = ch_e == 8'h2C;
  wire is_dash  = ch_e == 8'h2D;
  wire is_slash = ch_e == 8'h2F;
  wire is_star  = ch_e == 8'h2A;
  wire is_digit = ch_e >= 8'h30 && ch_e <= 8'h39;
  wire active   = field_index < 3'(FieldCount);

  // Evaluation that the current character triggers
  wire ends_field = in_field && is_space;
  wire item_nonempty = !(item_phase == PH_PLAIN && part_star == PS_EMPTY);
  wire eval_now = active && line_ok && !field_hit &&
                  ((!is_space && is_comma) || (ends_field && item_nonempty));
  wire eval_range = item_phase == PH_DASH || item_phase == PH_RANGE_STEP;

  // Range operands for the pending evaluation
  wire [NB-1:0] r_start = range_start;
  wire [NB-1:0] r_end  = (item_phase == PH_DASH) ? number_accum : range_end;
  wire [NB-1:0] r_step = (item_phase == PH_DASH) ? NB'(1) : number_accum;
  wire r_bad = r_step == '0 || r_end > hi || r_end < lo;

  logic simple_hit;
  always_comb begin
    unique case (item_phase)
      PH_PLAIN:    simple_hit = part_star == PS_STAR || number_accum == NB'(cur);
      PH_NUM_STEP: simple_hit = range_start == NB'(cur);
      default:     simple_hit = 1'b0;
    endcase
  end

  // Walk: count mod step tracked by w_cnt counting down to 1
  wire w_hit = w_cnt == NB'(1) && w_pos == NB'(cur);
  wire w_fin = w_hit || w_pos == w_end;

  assign sts.need_walk = step_in && eval_now && eval_range && !r_bad;
  assign sts.walk_done = w_fin;

  logic [NB-1:0] digit_sum;
  logic [NB+3:0] acc_wide;
  always_comb begin
    acc_wide = (NB+4)'(number_accum) * (NB+4)'(10) + (NB+4)'(ch_e - 8'h30);
    digit_sum = (acc_wide > (NB+4)'(MaxNum)) ? MaxNum : acc_wide[NB-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      now_minute <= '0; now_hour <= '0; now_day <= 5'd1;
      now_month <= 4'd1; now_weekday <= '0;
      field_index <= '0; line_ok <= 1'b1; field_hit <= 1'b0;
      error_seen <= 1'b0; in_field <= 1'b0;
      number_accum <= '0; range_start <= '0; range_end <= '0;
      item_phase <= PH_PLAIN; part_star <= PS_EMPTY;
      w_pos <= '0; w_cnt <= '0; w_end <= '0; w_step <= '0;
      pend_field_end <= 1'b0; pend_last <= 1'b0;
      match <= 1'b0; malformed <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          RegMinute:  now_minute <= cfg_data;
          RegHour:    now_hour <= cfg_data[4:0];
          RegDay:     now_day <= cfg_data[4:0];
          RegMonth:   now_month <= cfg_data[3:0];
          RegWeekday: now_weekday <= cfg_data[2:0];
          default: ;
        endcase
      end
      if (step_in) begin
        if (sts.need_walk) begin
          // hold parse state; walker finishes the evaluation
          w_end <= r_end; w_step <= r_step;
          w_pos <= (r_start > hi) ? lo : r_start;
          w_cnt <= r_step;
          pend_field_end <= ends_field;
          pend_last <= last_e;
        end else begin
          if (eval_now) begin
            if (eval_range) error_seen <= 1'b1;
            else if (simple_hit) field_hit <= 1'b1;
          end
          if (ends_field) begin
            if (active) begin
              if (line_ok && !field_hit && !(eval_now && !eval_range && simple_hit))
                line_ok <= 1'b0;
              field_index <= field_index + 3'd1;
            end
            field_hit <= 1'b0;
            number_accum <= '0; range_start <= '0; range_end <= '0;
            item_phase <= PH_PLAIN; part_star <= PS_EMPTY;
            in_field <= 1'b0;
          end
          if (!is_space) begin
            in_field <= 1'b1;
            if (active) begin
              priority if (is_comma) begin
                number_accum <= '0; range_start <= '0; range_end <= '0;
                item_phase <= PH_PLAIN; part_star <= PS_EMPTY;
              end else if (is_dash && item_phase == PH_PLAIN) begin
                range_start <= number_accum; item_phase <= PH_DASH;
                number_accum <= '0; part_star <= PS_EMPTY;
              end else if (is_slash && item_phase == PH_PLAIN) begin
                if (part_star == PS_STAR) begin
                  range_start <= lo; range_end <= hi; item_phase <= PH_RANGE_STEP;
                end else begin
                  range_start <= number_accum; item_phase <= PH_NUM_STEP;
                end
                number_accum <= '0; part_star <= PS_EMPTY;
              end else if (is_slash && item_phase == PH_DASH) begin
                range_end <= number_accum; item_phase <= PH_RANGE_STEP;
                number_accum <= '0; part_star <= PS_EMPTY;
              end else if (is_digit) begin
                if (part_star == PS_EMPTY || part_star == PS_DIGITS) begin
                  number_accum <= digit_sum; part_star <= PS_DIGITS;
                end else part_star <= PS_CLOSED;
              end else if (is_star && part_star == PS_EMPTY) begin
                part_star <= PS_STAR;
              end else part_star <= PS_CLOSED;
            end
          end
          if (last_e) begin
            match <= line_ok && !(ends_field && active && !field_hit &&
                     !(eval_now && !eval_range && simple_hit));
            malformed <= error_seen || (eval_now && eval_range);
          end
        end
      end
      if (cmd.walk_step) begin
        if (w_fin) begin
          if (w_hit) field_hit <= 1'b1;
          number_accum <= '0; range_start <= '0; range_end <= '0;
          item_phase <= PH_PLAIN; part_star <= PS_EMPTY;
          if (pend_field_end) begin
            if (active) begin
              if (line_ok && !w_hit) line_ok <= 1'b0;
              field_index <= field_index + 3'd1;
            end
            field_hit <= 1'b0;
            in_field <= 1'b0;
          end
          if (pend_last) begin
            match <= line_ok && !(pend_field_end && !w_hit);
            malformed <= error_seen;
          end
        end else begin
          w_pos <= (w_pos + NB'(1) > hi) ? lo : w_pos + NB'(1);
          w_cnt <= (w_cnt == NB'(1)) ? w_step : w_cnt - NB'(1);
        end
      end
      if (cmd.finish) begin
        field_index <= '0; line_ok <= 1'b1; field_hit <= 1'b0;
        error_seen <= 1'b0; in_field <= 1'b0;
        number_accum <= '0; range_start <= '0; range_end <= '0;
        item_phase <= PH_PLAIN; part_star <= PS_EMPTY;
      end
    end
  end
endmodule
`default_nettype wire

@@ sv/csm_control.sv @@
// Sequencer: accepts characters, runs range walks, presents the verdict.
`default_nettype none
module csm_control (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_last,
  output logic                    out_valid,
  input  wire logic               out_stall,
  input  wire csm_pkg::dp_sts_t   sts,
  output csm_pkg::dp_cmd_t        cmd
);
  import csm_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_WALK, S_CLOSE, S_CLEAR} state_t;
  state_t state;
  logic   held_last;
  logic   closing;   // the running walk belongs to the line close

  wire out_free = !out_valid || !out_stall;
  wire accept = state == S_IDLE && in_valid;

  assign in_stall = state != S_IDLE;

  always_comb begin
    cmd = '0;
    cmd.take = accept;
    // hold the close until the previous verdict is gone
    cmd.close = state == S_CLOSE && out_free;
    cmd.walk_step = state == S_WALK;
    cmd.finish = state == S_CLEAR;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; out_valid <= 1'b0; held_last <= 1'b0; closing <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (accept) begin
          held_last <= in_last;
          closing <= 1'b0;
          if (sts.need_walk) state <= S_WALK;
          else if (in_last) state <= S_CLOSE;
        end
        S_WALK: if (sts.walk_done) begin
          if (closing) begin
            out_valid <= 1'b1; state <= S_CLEAR;
          end else if (held_last) state <= S_CLOSE;
          else state <= S_IDLE;
        end
        S_CLOSE: if (out_free) begin
          if (sts.need_walk) begin
            closing <= 1'b1; state <= S_WALK;
          end else begin
            out_valid <= 1'b1; state <= S_CLEAR;
          end
        end
        S_CLEAR: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ sv/cron_schedule_matcher.sv @@
// Cron schedule matcher top level.
// Takes one schedule character per transaction; a character that needs no
// range walk and is not flagged last leaves the input ready, so the next
// can follow at once. A comma or space that closes a range item needing
// evaluation (start-end, start-end/step or star/step) stalls the input
// while the datapath walks the range one position per cycle, ending early
// on a hit. After the character flagged last, the close step closes the
// open field (plus a walk if it ends in a range), the verdict is raised,
// and the clear step then clears the parse state. The verdict holds
// until taken; a waiting verdict only delays the close of the next line.
`default_nettype none
module cron_schedule_matcher #(
  parameter int NUMBER_BITS = 8
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire csm_pkg::in_item_t   in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output csm_pkg::out_item_t       out_data,
  input  wire logic                cfg_we,
  input  wire logic [2:0]          cfg_index,
  input  wire logic [5:0]          cfg_data
);
  import csm_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic match, malformed;

  csm_control u_ctl (
    .clk, .rst, .in_valid, .in_stall, .in_last(in_data.last),
    .out_valid, .out_stall, .sts, .cmd
  );

  csm_datapath #(.NUMBER_BITS(NUMBER_BITS)) u_dp (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .ch(in_data.ch), .cmd, .sts, .match, .malformed
  );

  assign out_data.match = match;
  assign out_data.malformed = malformed;
endmodule
`default_nettype wire
